@@ hw/rtl/ffc_pkg.sv @@
`timescale 1ns / 1ps

package ffc_pkg;

	// Window search bound: a "[FontMap]" match must end below this offset
	localparam int SEARCH_LIMIT = 64;

	localparam int CNT_W      = 11;
	localparam int HEAD_LEN   = 18;
	localparam int TAG_LEN    = 4;
	localparam int WIN_LEN    = 8;
	localparam int HEAD_IDX_W = $clog2(HEAD_LEN);
	localparam int TAG_IDX_W  = $clog2(TAG_LEN);

	localparam logic [CNT_W-1:0] COUNT_CEIL = CNT_W'(1084);
	localparam logic [CNT_W-1:0] TRK_BASE   = CNT_W'(44);
	localparam logic [CNT_W-1:0] MOD_BASE   = CNT_W'(1080);
	localparam logic [CNT_W-1:0] SRCH_LIM   = CNT_W'(SEARCH_LIMIT);

	// Byte k of a store sits at index k
	typedef logic [HEAD_LEN-1:0][7:0] head_t;
	typedef logic [TAG_LEN-1:0][7:0]  tag_t;
	typedef logic [WIN_LEN-1:0][7:0]  win_t;

	// Magic strings, first byte in the top bits
	localparam logic [71:0]  FONTMAP_TEXT = "[FontMap]";
	localparam logic [127:0] XM_TEXT      = "Extended Module:";
	localparam logic [31:0]  MAP_TEXT     = {"MAP", 8'h01};
	localparam logic [31:0]  RIFF_TEXT    = "RIFF";
	localparam logic [31:0]  WAVE_TEXT    = "WAVE";
	localparam logic [31:0]  OGG_TEXT     = "OggS";
	localparam logic [31:0]  PNG_TEXT     = {8'h89, "PNG"};
	localparam logic [15:0]  BM_TEXT      = "BM";
	localparam logic [23:0]  GIF_TEXT     = "GIF";
	localparam logic [23:0]  TGA_TEXT     = {8'h00, 8'h00, 8'h02};
	localparam logic [23:0]  ID3_TEXT     = "ID3";
	localparam logic [23:0]  JPG_TEXT     = {8'hFF, 8'hD8, 8'hFF};
	localparam logic [31:0]  MTHD_TEXT    = "MThd";
	localparam logic [31:0]  IMPM_TEXT    = "IMPM";
	localparam logic [31:0]  SCRM_TEXT    = "SCRM";
	localparam logic [31:0]  MK_TEXT      = "M.K.";
	localparam logic [31:0]  MK2_TEXT     = "M!K!";
	localparam logic [31:0]  FLT4_TEXT    = "FLT4";
	localparam logic [31:0]  FLT8_TEXT    = "FLT8";
	localparam logic [7:0]   SYNC_BYTE    = 8'hFF;
	localparam logic [7:0]   SYNC_MASK    = 8'hE0;
	localparam logic [7:0]   SOI_BYTE     = 8'hD8;

	typedef enum logic [3:0] {
		FMT_BIN = 4'd0,
		FMT_MAP = 4'd1,
		FMT_WAV = 4'd2,
		FMT_OGG = 4'd3,
		FMT_PNG = 4'd4,
		FMT_BMP = 4'd5,
		FMT_GIF = 4'd6,
		FMT_TGA = 4'd7,
		FMT_MP3 = 4'd8,
		FMT_JPG = 4'd9,
		FMT_MID = 4'd10,
		FMT_XM  = 4'd11,
		FMT_IT  = 4'd12,
		FMT_S3M = 4'd13,
		FMT_MOD = 4'd14,
		FMT_CFG = 4'd15
	} fmt_t;

	typedef enum logic [2:0] {
		KIND_BINARY = 3'd0,
		KIND_MAP    = 3'd1,
		KIND_AUDIO  = 3'd2,
		KIND_IMAGE  = 3'd3,
		KIND_FONT   = 3'd4
	} kind_t;

	typedef struct packed {
		fmt_t  fmt;
		kind_t kind;
		logic  mime;
	} class_t;

	// Leading bytes of a store, first byte in the top bits
	function automatic logic [31:0] tag_str(input tag_t t);
		logic [31:0] r;
		for (int i = 0; i < TAG_LEN; i++) begin
			r[31-8*i -: 8] = t[i];
		end
		return r;
	endfunction

	function automatic logic [127:0] head16(input head_t h);
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			r[127-8*i -: 8] = h[i];
		end
		return r;
	endfunction

	function automatic logic [63:0] win_str(input win_t w);
		logic [63:0] r;
		for (int i = 0; i < WIN_LEN; i++) begin
			r[63-8*i -: 8] = w[i];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/file_header_format_classifier_top.sv @@
`timescale 1ns / 1ps

// File header format classifier.
// Input channel (in_valid/in_ready): one request per file byte, in offset
// order, with byte_present (0 = no byte, marks an empty file) and
// last_byte (1 on the final request of a file).
// Output channel (out_valid/out_ready): one result per file, carrying
// format_code, asset_kind and mime_known, issued for the last_byte request.
// Throughput: one request per cycle. Each request is held in the input
// register, then updates the captured header state; a last request
// also loads the result register, which drives the output channel.
// The header state then clears, so the next file can stream in at once.
// When the receiver stalls, non-final bytes keep flowing; a final request
// waits in the input register until the held result is taken, and in_ready
// stays low while it waits.
// Reset (arst_n low) empties both registers and clears all header state;
// no results are pending afterwards.

module file_header_format_classifier_top
	import ffc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] format_code,
	output logic [2:0] asset_kind,
	output logic       mime_known
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;
	logic       advance;

	// Header state
	logic [CNT_W-1:0] count_q;
	head_t            head_q;
	tag_t             trk_q;
	tag_t             mod_q;
	win_t             win_q;
	logic             seen_q;

	// State after taking the byte in the input register
	logic [CNT_W-1:0] count_nx;
	head_t            head_nx;
	tag_t             trk_nx;
	tag_t             mod_nx;
	win_t             win_nx;
	logic             seen_nx;
	logic             font_hit;

	class_t class_w;
	logic   out_valid_q;
	class_t result_q;

	// A final request moves on only when the result register is free
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1    <= data_byte;
			present_s1 <= byte_present;
			last_s1    <= last_byte;
		end
	end

	// "[FontMap]" ending on this byte
	assign font_hit = (win_str(win_q) == FONTMAP_TEXT[71:8]) &&
		(byte_s1 == FONTMAP_TEXT[7:0]);

	// Byte capture
	always_comb begin
		count_nx = count_q;
		head_nx  = head_q;
		trk_nx   = trk_q;
		mod_nx   = mod_q;
		win_nx   = win_q;
		seen_nx  = seen_q;
		if (present_s1) begin
			if (count_q < CNT_W'(HEAD_LEN)) begin
				head_nx[count_q[HEAD_IDX_W-1:0]] = byte_s1;
			end
			if (count_q >= TRK_BASE && count_q < TRK_BASE + CNT_W'(TAG_LEN)) begin
				trk_nx[count_q[TAG_IDX_W-1:0]] = byte_s1;
			end
			if (count_q >= MOD_BASE && count_q < MOD_BASE + CNT_W'(TAG_LEN)) begin
				mod_nx[count_q[TAG_IDX_W-1:0]] = byte_s1;
			end
			if (font_hit && count_q >= CNT_W'(8) && count_q < SRCH_LIM) begin
				seen_nx = 1'b1;
			end
			win_nx = {byte_s1, win_q[WIN_LEN-1:1]};
			if (count_q < COUNT_CEIL) begin
				count_nx = count_q + CNT_W'(1);
			end
		end
	end

	ffc_classify u_classify (
		.count     (count_nx),
		.head      (head_nx),
		.trk_tag   (trk_nx),
		.mod_tag   (mod_nx),
		.font_seen (seen_nx),
		.result    (class_w)
	);

	// State update; cleared after each classification
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			trk_q   <= '0;
			mod_q   <= '0;
			win_q   <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				count_q <= '0;
				head_q  <= '0;
				trk_q   <= '0;
				mod_q   <= '0;
				win_q   <= '0;
				seen_q  <= 1'b0;
			end else begin
				count_q <= count_nx;
				head_q  <= head_nx;
				trk_q   <= trk_nx;
				mod_q   <= mod_nx;
				win_q   <= win_nx;
				seen_q  <= seen_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= class_w;
		end
	end

	assign out_valid   = out_valid_q;
	assign format_code = result_q.fmt;
	assign asset_kind  = result_q.kind;
	assign mime_known  = result_q.mime;

endmodule

@@ hw/rtl/ffc_classify.sv @@
`timescale 1ns / 1ps

module ffc_classify
	import ffc_pkg::*;
(
	input  logic [CNT_W-1:0] count,
	input  head_t            head,
	input  tag_t             trk_tag,
	input  tag_t             mod_tag,
	input  logic             font_seen,
	output class_t           result
);

	logic [31:0] h4;
	logic [23:0] h3;
	logic [15:0] h2;
	logic [31:0] h_wave;
	logic [31:0] m4;
	logic        tga_depth;
	logic        mp3_sync;
	logic        mod_tag_hit;

	// Prefix views of the header, the WAVE field at bytes 8 to 11, and the module tag
	always_comb begin
		h4     = {head[0], head[1], head[2], head[3]};
		h3     = h4[31:8];
		h2     = h4[31:16];
		h_wave = {head[8], head[9], head[10], head[11]};
		m4     = tag_str(mod_tag);
	end

	assign tga_depth = (head[16] == 8'd8) || (head[16] == 8'd16) ||
		(head[16] == 8'd24) || (head[16] == 8'd32);
	assign mp3_sync = (head[0] == SYNC_BYTE) && ((head[1] & SYNC_MASK) == SYNC_MASK) &&
		(head[1] != SOI_BYTE);
	assign mod_tag_hit = (m4 == MK_TEXT) || (m4 == MK2_TEXT) || (m4 == FLT4_TEXT) ||
		(m4 == FLT8_TEXT);

	// Ordered rule list, first match wins
	always_comb begin
		result = '{fmt: FMT_BIN, kind: KIND_BINARY, mime: 1'b1};
		if (count >= CNT_W'(4) && h4 == MAP_TEXT) begin
			result = '{fmt: FMT_MAP, kind: KIND_MAP, mime: 1'b1};
		end else if (count >= CNT_W'(12) && h4 == RIFF_TEXT && h_wave == WAVE_TEXT) begin
			result = '{fmt: FMT_WAV, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h4 == OGG_TEXT) begin
			result = '{fmt: FMT_OGG, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h4 == PNG_TEXT) begin
			result = '{fmt: FMT_PNG, kind: KIND_IMAGE, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h2 == BM_TEXT) begin
			result = '{fmt: FMT_BMP, kind: KIND_IMAGE, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h3 == GIF_TEXT) begin
			result = '{fmt: FMT_GIF, kind: KIND_IMAGE, mime: 1'b1};
		end else if (count >= CNT_W'(18) && h3 == TGA_TEXT && tga_depth) begin
			result = '{fmt: FMT_TGA, kind: KIND_IMAGE, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h3 == ID3_TEXT) begin
			result = '{fmt: FMT_MP3, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h3 == JPG_TEXT) begin
			result = '{fmt: FMT_JPG, kind: KIND_IMAGE, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h4 == MTHD_TEXT) begin
			result = '{fmt: FMT_MID, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(4) && mp3_sync) begin
			result = '{fmt: FMT_MP3, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(2) && h2 == BM_TEXT) begin
			// short bitmap stub: format known, no MIME type
			result = '{fmt: FMT_BMP, kind: KIND_IMAGE, mime: 1'b0};
		end else if (count >= CNT_W'(17) && head16(head) == XM_TEXT) begin
			result = '{fmt: FMT_XM, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(4) && h4 == IMPM_TEXT) begin
			result = '{fmt: FMT_IT, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(48) && tag_str(trk_tag) == SCRM_TEXT) begin
			result = '{fmt: FMT_S3M, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= COUNT_CEIL && mod_tag_hit) begin
			result = '{fmt: FMT_MOD, kind: KIND_AUDIO, mime: 1'b1};
		end else if (count >= CNT_W'(8) && font_seen) begin
			result = '{fmt: FMT_CFG, kind: KIND_FONT, mime: 1'b1};
		end
	end

endmodule

@@ sim/tb_file_header_format_classifier_top.sv @@
`timescale 1ns / 1ps

module tb_file_header_format_classifier_top
	import ffc_pkg::*;
();

	// Tracks the header state of the file being streamed in and keeps the
	// classification owed for every completed file, oldest first.
	class header_scoreboard;
		int unsigned     bytes_taken;
		bit [7:0]        head [HEAD_LEN];
		bit [7:0]        tracker_tag [TAG_LEN];
		bit [7:0]        module_tag [TAG_LEN];
		bit [7:0]        window [WIN_LEN];
		bit              fontmap_found;
		class_t          expected_formats[$];
		int              mismatches;
		int              reported;
		int              files_seen;
		int              format_hits [16];

		function new();
			clear_file();
		endfunction

		function void clear_file();
			bytes_taken   = 0;
			fontmap_found = 1'b0;
			foreach (head[i]) head[i] = 8'h00;
			foreach (tracker_tag[i]) tracker_tag[i] = 8'h00;
			foreach (module_tag[i]) module_tag[i] = 8'h00;
			foreach (window[i]) window[i] = 8'h00;
		endfunction

		function bit head_at(int off, string s);
			for (int i = 0; i < s.len(); i++) begin
				if (head[off+i] != s[i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function bit tag_is(input bit [7:0] t [TAG_LEN], string s);
			for (int i = 0; i < TAG_LEN; i++) begin
				if (t[i] != s[i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function class_t result_of(fmt_t f, kind_t k, logic m);
			class_t r;
			r.fmt  = f;
			r.kind = k;
			r.mime = m;
			return r;
		endfunction

		// Capture one byte at the current offset and run the "[FontMap]" window
		function void take_byte(bit [7:0] b);
			int unsigned p;
			string       lead;
			bit          hit;
			p    = bytes_taken;
			lead = "[FontMap";
			hit  = (b == "]");
			if (p < HEAD_LEN) head[p] = b;
			if (p >= 44 && p < 48) tracker_tag[p-44] = b;
			if (p >= 1080 && p < 1084) module_tag[p-1080] = b;
			for (int i = 0; i < WIN_LEN; i++) begin
				if (window[i] != lead[i]) hit = 1'b0;
			end
			if (hit && p >= 8 && p < SEARCH_LIMIT) fontmap_found = 1'b1;
			for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i+1];
			window[WIN_LEN-1] = b;
			if (bytes_taken < 1084) bytes_taken++;
		endfunction

		// Ordered magic-number rules; first match wins
		function class_t classify();
			int unsigned n;
			n = bytes_taken;
			if (n >= 4) begin
				if (head_at(0, "MAP") && head[3] == 8'h01)
					return result_of(FMT_MAP, KIND_MAP, 1'b1);
				if (head_at(0, "RIFF") && n >= 12 && head_at(8, "WAVE"))
					return result_of(FMT_WAV, KIND_AUDIO, 1'b1);
				if (head_at(0, "OggS")) return result_of(FMT_OGG, KIND_AUDIO, 1'b1);
				if (head[0] == 8'h89 && head_at(1, "PNG"))
					return result_of(FMT_PNG, KIND_IMAGE, 1'b1);
				if (head_at(0, "BM")) return result_of(FMT_BMP, KIND_IMAGE, 1'b1);
				if (head_at(0, "GIF")) return result_of(FMT_GIF, KIND_IMAGE, 1'b1);
				if (n >= 18 && head[0] == 8'h00 && head[1] == 8'h00 && head[2] == 8'h02 &&
					head[16] inside {8'd8, 8'd16, 8'd24, 8'd32})
					return result_of(FMT_TGA, KIND_IMAGE, 1'b1);
				if (head_at(0, "ID3")) return result_of(FMT_MP3, KIND_AUDIO, 1'b1);
				if (head[0] == 8'hFF && head[1] == 8'hD8 && head[2] == 8'hFF)
					return result_of(FMT_JPG, KIND_IMAGE, 1'b1);
				if (head_at(0, "MThd")) return result_of(FMT_MID, KIND_AUDIO, 1'b1);
				// frame sync: 0xFF then top three bits set
				if (head[0] == 8'hFF && (head[1] & 8'hE0) == 8'hE0 && head[1] != 8'hD8)
					return result_of(FMT_MP3, KIND_AUDIO, 1'b1);
			end
			if (n >= 2 && head_at(0, "BM")) return result_of(FMT_BMP, KIND_IMAGE, 1'b0);
			if (n >= 17 && head_at(0, "Extended Module:"))
				return result_of(FMT_XM, KIND_AUDIO, 1'b1);
			if (n >= 4 && head_at(0, "IMPM")) return result_of(FMT_IT, KIND_AUDIO, 1'b1);
			if (n >= 48 && tag_is(tracker_tag, "SCRM"))
				return result_of(FMT_S3M, KIND_AUDIO, 1'b1);
			if (n >= 1084 && (tag_is(module_tag, "M.K.") || tag_is(module_tag, "M!K!") ||
				tag_is(module_tag, "FLT4") || tag_is(module_tag, "FLT8")))
				return result_of(FMT_MOD, KIND_AUDIO, 1'b1);
			if (n >= 8 && fontmap_found) return result_of(FMT_CFG, KIND_FONT, 1'b1);
			return result_of(FMT_BIN, KIND_BINARY, 1'b1);
		endfunction

		// Accepted input request
		function void note_request(bit [7:0] d, bit present, bit is_last);
			class_t r;
			if (present) take_byte(d);
			if (is_last) begin
				r = classify();
				expected_formats.push_back(r);
				format_hits[r.fmt]++;
				files_seen++;
				clear_file();
			end
		endfunction

		// Accepted result, compared with the oldest owed classification
		function void check_result(logic [3:0] f, logic [2:0] k, logic m);
			class_t want;
			if (expected_formats.size() == 0) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("[%0t] unexpected result: format %0d kind %0d mime %0d",
						$time, f, k, m);
				end
				return;
			end
			want = expected_formats.pop_front();
			if (f !== want.fmt || k !== want.kind || m !== want.mime) begin
				mismatches++;
				if (reported < 10) begin
					reported++;
					$display("[%0t] mismatch: format %0d/%0d kind %0d/%0d mime %0d/%0d (exp/got)",
						$time, want.fmt, f, want.kind, k, want.mime, m);
				end
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_FILES = 12;

	typedef enum int {
		SH_NOISE, SH_MAP, SH_WAV, SH_OGG, SH_PNG, SH_BMP, SH_GIF, SH_TGA, SH_ID3,
		SH_JPG, SH_MID, SH_SYNC, SH_XM, SH_IT, SH_S3M, SH_FONT
	} shape_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOKED} rx_mode_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b1;
	logic       in_valid     = 1'b0;
	logic [7:0] data_byte    = 8'h00;
	logic       byte_present = 1'b0;
	logic       last_byte    = 1'b0;
	logic       out_ready    = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [3:0] format_code;
	logic [2:0] asset_kind;
	logic       mime_known;

	header_scoreboard sb = new();
	bit [7:0]         file_bytes[$];
	int               burst_left;
	int               bytes_sent;
	int               blank_requests;
	int               idle_cycles;
	rx_mode_t         rx_mode;
	int               rx_left;

	file_header_format_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.format_code  (format_code),
		.asset_kind   (asset_kind),
		.mime_known   (mime_known)
	);

	always #2 clk = ~clk;

	// Receiver: check results, ready follows phases of open/random/choked
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(format_code, asset_kind, mime_known);
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(16, 160);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
			default:   out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Watchdog on cycles with no request and no result moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// One input request; sender runs in bursts with random gaps between them
	task automatic put_request(input logic [7:0] d, input logic p, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		data_byte    <= d;
		byte_present <= p;
		last_byte    <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(d, p, l);
		if (p) bytes_sent++;
		else blank_requests++;
	endtask

	// Stream file_bytes; stray no-byte requests sprinkled in, optional no-byte finish
	task automatic send_file(input bit blank_finish);
		int len;
		len = file_bytes.size();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) put_request(8'($urandom), 1'b0, 1'b0);
			put_request(file_bytes[i], 1'b1, (i == len - 1) && !blank_finish);
		end
		if (len == 0 || blank_finish) put_request(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic void fresh_file(int len);
		file_bytes.delete();
		repeat (len) file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void place_byte(int off, bit [7:0] b);
		while (file_bytes.size() <= off) file_bytes.push_back(8'($urandom));
		file_bytes[off] = b;
	endfunction

	function automatic void place_text(int off, string s);
		for (int i = 0; i < s.len(); i++) place_byte(off + i, s[i]);
	endfunction

	function automatic void trim_to(int len);
		while (file_bytes.size() > len) void'(file_bytes.pop_back());
	endfunction

	task automatic send_text(input int off, input string s, input int len);
		fresh_file(len);
		place_text(off, s);
		trim_to(len);
		send_file(1'b0);
	endtask

	// Directed files: every rule, the BMP, WAV and XM length edges, and the window bounds
	task automatic run_directed();
		string mod_tags [4];
		mod_tags = '{"M.K.", "M!K!", "FLT4", "FLT8"};
		put_request(8'hA5, 1'b0, 1'b0);
		put_request(8'h5A, 1'b0, 1'b0);
		fresh_file(0);
		send_file(1'b0);
		send_text(0, "B", 1);
		send_text(0, "BM", 2);
		send_text(0, "BM", 3);
		send_text(0, "BM", 4);
		fresh_file(4);
		place_text(0, "MAP");
		place_byte(3, 8'h01);
		send_file(1'b0);
		fresh_file(12);
		place_text(0, "RIFF");
		place_text(8, "WAVE");
		send_file(1'b0);
		trim_to(11);
		send_file(1'b0);
		fresh_file(4);
		place_text(0, "OggS");
		send_file(1'b1);
		fresh_file(4);
		place_byte(0, 8'h89);
		place_text(1, "PNG");
		send_file(1'b0);
		send_text(0, "GIF", 6);
		fresh_file(18);
		place_byte(0, 8'h00);
		place_byte(1, 8'h00);
		place_byte(2, 8'h02);
		place_byte(16, 8'd24);
		send_file(1'b0);
		send_text(0, "ID3", 5);
		fresh_file(4);
		place_byte(0, 8'hFF);
		place_byte(1, 8'hD8);
		place_byte(2, 8'hFF);
		send_file(1'b0);
		send_text(0, "MThd", 4);
		fresh_file(4);
		place_byte(0, 8'hFF);
		place_byte(1, 8'hFB);
		send_file(1'b0);
		send_text(0, "Extended Module:", 17);
		send_text(0, "Extended Module:", 16);
		send_text(0, "IMPM", 4);
		send_text(44, "SCRM", 48);
		send_text(1080, mod_tags[$urandom_range(0, 3)], 1084);
		send_text(0, "[FontMap]", 9);
		send_text(55, "[FontMap]", 64);
		send_text(56, "[FontMap]", 70);
		fresh_file(0);
		repeat (8) file_bytes.push_back(8'hFF);
		send_file(1'b0);
		fresh_file(0);
		repeat (20) file_bytes.push_back(8'h00);
		send_file(1'b0);
	endtask

	// Random file: mostly a well-formed header with random body, some noise
	task automatic send_random_file();
		shape_t    shape;
		int        lmin;
		int        len;
		int        idx;
		bit [7:0]  depths [4];
		depths = '{8'd8, 8'd16, 8'd24, 8'd32};
		if ($urandom_range(0, 3) == 0) shape = SH_NOISE;
		else shape = shape_t'($urandom_range(SH_MAP, SH_FONT));
		lmin = 4;
		fresh_file(0);
		case (shape)
			SH_NOISE: lmin = 0;
			SH_MAP: begin
				place_text(0, "MAP");
				place_byte(3, 8'h01);
			end
			SH_WAV: begin
				place_text(0, "RIFF");
				place_text(8, "WAVE");
				lmin = 12;
			end
			SH_OGG: place_text(0, "OggS");
			SH_PNG: begin
				place_byte(0, 8'h89);
				place_text(1, "PNG");
			end
			SH_BMP: begin
				place_text(0, "BM");
				lmin = 2;
			end
			SH_GIF: begin
				place_text(0, "GIF");
				lmin = 3;
			end
			SH_TGA: begin
				place_byte(0, 8'h00);
				place_byte(1, 8'h00);
				place_byte(2, 8'h02);
				place_byte(16, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
					depths[$urandom_range(0, 3)]);
				lmin = 18;
			end
			SH_ID3: begin
				place_text(0, "ID3");
				lmin = 3;
			end
			SH_JPG: begin
				place_byte(0, 8'hFF);
				place_byte(1, 8'hD8);
				place_byte(2, 8'hFF);
				lmin = 3;
			end
			SH_MID: place_text(0, "MThd");
			SH_SYNC: begin
				place_byte(0, 8'hFF);
				place_byte(1, 8'hE0 | 8'($urandom_range(0, 31)));
			end
			SH_XM: begin
				place_text(0, "Extended Module:");
				lmin = 17;
			end
			SH_IT: place_text(0, "IMPM");
			SH_S3M: begin
				place_text(44, "SCRM");
				lmin = 48;
			end
			default: begin
				// font configuration text near the search bound
				lmin = $urandom_range(8, 72);
				place_text(lmin - 8, "[FontMap]");
				lmin++;
			end
		endcase
		// length around the minimum the rule needs, sometimes just short of it
		if (shape == SH_NOISE) len = $urandom_range(0, 24);
		else if ($urandom_range(0, 4) == 0) len = lmin - $urandom_range(1, 3);
		else len = lmin + $urandom_range(0, 12);
		if (len < 0) len = 0;
		while (file_bytes.size() < len) file_bytes.push_back(8'($urandom));
		trim_to(len);
		// occasional single-bit damage to the header or anywhere
		if (len > 0 && $urandom_range(0, 5) == 0) begin
			idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, len - 1) :
				$urandom_range(0, ((len < 18) ? len : 18) - 1);
			file_bytes[idx][$urandom_range(0, 7)] ^= 1'b1;
		end
		send_file($urandom_range(0, 9) == 0);
	endtask

	initial begin : main
		int formats_hit;
		int fails;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		repeat (RANDOM_FILES) send_random_file();
		in_valid <= 1'b0;
		while (sb.expected_formats.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		formats_hit = 0;
		foreach (sb.format_hits[i]) if (sb.format_hits[i] != 0) formats_hit++;
		fails = sb.mismatches + sb.expected_formats.size();
		$display("Classified %0d files from %0d bytes and %0d no-byte requests;",
			sb.files_seen, bytes_sent, blank_requests);
		$display("%0d of 16 formats hit. Mismatches: %0d.", formats_hit, fails);
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ file_header_format_classifier_top.f @@
hw/rtl/ffc_pkg.sv
hw/rtl/ffc_classify.sv
hw/rtl/file_header_format_classifier_top.sv
sim/tb_file_header_format_classifier_top.sv
